/* design/mmpf_pkg.sv */
`default_nettype none
package mmpf_pkg;

  localparam int QueueDepth = 16;
  localparam int PtrW = $clog2(QueueDepth);
  localparam int NumPush = 3;

  localparam logic [1:0] CmdMotion = 2'd0;
  localparam logic [1:0] CmdRead   = 2'd1;
  localparam logic [1:0] CmdReset  = 2'd2;

  localparam logic [1:0] ModeX   = 2'b01;
  localparam logic [1:0] ModeY   = 2'b10;
  localparam logic [1:0] ModeBtn = 2'b11;

  typedef struct packed {
    logic [NumPush-1:0]      valid;
    logic [NumPush-1:0][7:0] data;
  } mmpf_push_t;

  typedef struct packed {
    logic signed [8:0] whole;
    logic signed [8:0] rem;
  } mmpf_split_t;

  function automatic mmpf_split_t take_whole(input logic signed [8:0] frac,
                                             input logic signed [15:0] delta);
    logic signed [16:0] sum;
    logic signed [16:0] rem;
    mmpf_split_t        res;
    sum = 17'(frac) + 17'(delta);
    res.whole = sum[16:8] + 9'(sum[16] && (sum[7:0] != 8'd0));
    rem = sum - {res.whole, 8'h00};
    res.rem = rem[8:0];
    return res;
  endfunction

  function automatic logic [5:0] clamp6(input logic signed [8:0] v);
    logic [5:0] res;
    if (v > 9'sd31) begin
      res = 6'b011111;
    end else if (v < -9'sd32) begin
      res = 6'b100000;
    end else begin
      res = v[5:0];
    end
    return res;
  endfunction

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] res;
    if (ptr == PtrW'(QueueDepth - 1)) begin
      res = '0;
    end else begin
      res = ptr + PtrW'(1);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* design/mmpf_queue.sv */
`default_nettype none
module mmpf_queue import mmpf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire mmpf_push_t push_i,
  input  wire logic       pop_i,
  input  wire logic       clear_i,
  output logic            empty_o,
  output logic [7:0]      rd_data_o
);

  logic [7:0]      store_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q;
  logic [PtrW-1:0] wp;
  logic [PtrW-1:0] waddr [NumPush];
  logic [NumPush-1:0] we;

  // Pushes are taken in order; a push that finds the queue full is dropped.
  always_comb begin
    wp = wr_ptr_q;
    for (int i = 0; i < NumPush; i++) begin
      we[i] = 1'b0;
      waddr[i] = wp;
      if (push_i.valid[i] && (ptr_next(wp) != rd_ptr_q)) begin
        we[i] = 1'b1;
        wp = ptr_next(wp);
      end
    end
    wr_ptr_d = wp;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumPush; i++) begin
      if (we[i]) begin
        store_q[waddr[i]] <= push_i.data[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else if (clear_i) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
    end
  end

  assign empty_o   = (wr_ptr_q == rd_ptr_q);
  assign rd_data_o = store_q[rd_ptr_q];

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("Pop from an empty queue.");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_i |=> empty_o) else $error("Queue not empty after clear.");

  a_no_push_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (push_i.valid == '0)) else $error("Push and pop in one cycle.");

endmodule
`default_nettype wire

/* design/mouse_motion_packet_fifo_unit.sv */
// Each word is held in an input register, then a read's byte in the output register.
// Throughput: one word per cycle; reads stall only while the output register is held.
// A motion word may queue up to three bytes in the same cycle that processes it.
// Asynchronous reset clears accumulators, buttons, queue pointers and the handshake state.
// Queue storage is not cleared; only bytes written since the last clear are ever read.
`default_nettype none
module mouse_motion_packet_fifo_unit import mmpf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // dx_motion, dy_motion, button_bits, zero fill
  input  wire logic [1:0]  s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // status_byte
  output logic [0:0]       m_axis_tuser   // fifo_was_empty
);

  logic              in_valid_q;
  logic [1:0]        cmd_q;
  logic signed [15:0] dx_q, dy_q;
  logic [2:0]        btn_raw_q;

  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              out_empty_q;

  logic signed [8:0] frac_x_q, frac_y_q;
  logic [2:0]        prev_btn_q;

  logic        out_free, is_read, adv, in_take;
  logic        fire_motion, fire_read, fire_reset;
  mmpf_split_t split_x, split_y;
  logic signed [8:0] neg_y;
  logic [2:0]  btn;
  logic        btn_change;
  mmpf_push_t  push;
  logic        q_empty;
  logic [7:0]  q_rd_data;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign is_read       = (cmd_q == CmdRead);
  assign adv           = in_valid_q && (!is_read || out_free);
  assign s_axis_tready = !in_valid_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign fire_motion = adv && (cmd_q == CmdMotion);
  assign fire_read   = adv && is_read;
  assign fire_reset  = adv && (cmd_q == CmdReset);

  assign split_x    = take_whole(frac_x_q, dx_q);
  assign split_y    = take_whole(frac_y_q, dy_q);
  assign neg_y      = 9'sd0 - split_y.whole;
  assign btn        = {btn_raw_q[1], btn_raw_q[2], btn_raw_q[0]};
  assign btn_change = (btn != prev_btn_q);

  always_comb begin
    push.valid[0] = fire_motion && (split_x.whole != 9'sd0);
    push.valid[1] = fire_motion && (split_y.whole != 9'sd0);
    push.valid[2] = fire_motion && btn_change;
    push.data[0]  = {ModeX, clamp6(split_x.whole)};
    push.data[1]  = {ModeY, clamp6(neg_y)};
    push.data[2]  = {ModeBtn, 3'b000, btn};
  end

  mmpf_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .pop_i     (fire_read && !q_empty),
    .clear_i   (fire_reset),
    .empty_o   (q_empty),
    .rd_data_o (q_rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q     <= s_axis_tuser;
      dx_q      <= s_axis_tdata[15:0];
      dy_q      <= s_axis_tdata[31:16];
      btn_raw_q <= s_axis_tdata[34:32];
    end
    if (fire_read) begin
      out_byte_q  <= q_empty ? 8'h00 : q_rd_data;
      out_empty_q <= q_empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      frac_x_q    <= '0;
      frac_y_q    <= '0;
      prev_btn_q  <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (fire_read) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (fire_reset) begin
        frac_x_q   <= '0;
        frac_y_q   <= '0;
        prev_btn_q <= '0;
      end else if (fire_motion) begin
        frac_x_q   <= split_x.rem;
        frac_y_q   <= split_y.rem;
        prev_btn_q <= btn;
      end
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_byte_q;
  assign m_axis_tuser[0] = out_empty_q;

  a_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |=> in_valid_q) else $error("Pending word lost.");

  a_empty_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> (out_byte_q == 8'h00))
    else $error("Empty read returned a nonzero byte.");

  a_read_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && is_read && !out_free) |-> !s_axis_tready)
    else $error("Input taken while a read is blocked.");

endmodule
`default_nettype wire
